@@ design/grid_point_binning_unit_defines.svh @@
// Assertion helpers for the grid point binning unit
`ifndef GRID_POINT_BINNING_UNIT_DEFINES_SVH
`define GRID_POINT_BINNING_UNIT_DEFINES_SVH

// Implication checked in the same cycle
`define GPB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grid binning check failed");

// Implication checked in the next cycle
`define GPB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grid binning check failed");

`endif

@@ design/gpb_pkg.sv @@
package gpb_pkg;

    // Grid geometry and cell store sizing
    localparam int GRID_SIDE = 16;
    localparam int GRID_W    = $clog2(GRID_SIDE);
    localparam int STEP_W    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W    = 2 * GRID_W;
    localparam int CELL_CAP  = 64;
    localparam int SLOT_W    = $clog2(CELL_CAP);
    localparam int CNT_W     = $clog2(CELL_CAP + 1);
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SKIP  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_CELL_WIDTH  = 3'd2,
        CFG_CELL_HEIGHT = 3'd3,
        CFG_INVALID     = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CHECK,
        S_DIV_X,
        S_LOAD_Y,
        S_DIV_Y,
        S_CNT_RD,
        S_INS,
        S_RD_CHK,
        S_RD_CAP,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic zero;
        logic clr_cnt;
        logic skip;
        logic load_x;
        logic load_y;
        logic step;
        logic cnt_rd;
        logic ins;
        logic rd_chk;
        logic rd_cap;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic invalid;
        logic div_last;
        logic is_insert;
    } t_dp_status;

endpackage

@@ design/gpb_ctrl.sv @@
module gpb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  gpb_pkg::t_func      i_func,
    input  gpb_pkg::t_dp_status i_status,
    output gpb_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_valid
);

    gpb_pkg::t_state r_state;
    gpb_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            gpb_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    unique case (i_func) inside
                        gpb_pkg::FUNC_CLEAR, gpb_pkg::FUNC_NONE: n_state = gpb_pkg::S_CLEAR;
                        gpb_pkg::FUNC_INSERT:                    n_state = gpb_pkg::S_CHECK;
                        gpb_pkg::FUNC_READ:                      n_state = gpb_pkg::S_CNT_RD;
                        default:                                 n_state = gpb_pkg::S_CLEAR;
                    endcase
                end
            end
            gpb_pkg::S_CLEAR: begin
                // func 3 gives the same all-zero result but keeps the counts
                o_cmd.zero    = 1'b1;
                o_cmd.clr_cnt = !i_status.is_insert;
                n_state       = gpb_pkg::S_OUT;
            end
            gpb_pkg::S_CHECK: begin
                if (i_status.invalid) begin
                    o_cmd.skip = 1'b1;
                    n_state    = gpb_pkg::S_OUT;
                end else begin
                    o_cmd.load_x = 1'b1;
                    n_state      = gpb_pkg::S_DIV_X;
                end
            end
            gpb_pkg::S_DIV_X: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = gpb_pkg::S_LOAD_Y;
                end
            end
            gpb_pkg::S_LOAD_Y: begin
                o_cmd.load_y = 1'b1;
                n_state      = gpb_pkg::S_DIV_Y;
            end
            gpb_pkg::S_DIV_Y: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = gpb_pkg::S_CNT_RD;
                end
            end
            gpb_pkg::S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = i_status.is_insert ? gpb_pkg::S_INS : gpb_pkg::S_RD_CHK;
            end
            gpb_pkg::S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = gpb_pkg::S_OUT;
            end
            gpb_pkg::S_RD_CHK: begin
                o_cmd.rd_chk = 1'b1;
                n_state      = gpb_pkg::S_RD_CAP;
            end
            gpb_pkg::S_RD_CAP: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = gpb_pkg::S_OUT;
            end
            gpb_pkg::S_OUT: begin
                n_state = gpb_pkg::S_IDLE;
            end
            default: begin
                n_state = gpb_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != gpb_pkg::S_IDLE);
    assign o_valid = (r_state == gpb_pkg::S_OUT);

endmodule

@@ design/gpb_datapath.sv @@
module gpb_datapath #(
    parameter int COORD_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gpb_pkg::t_dp_cmd                    i_cmd,
    output gpb_pkg::t_dp_status                 o_status,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [gpb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [COORD_BITS-1:0]               i_cfg_data,
    // request fields
    input  gpb_pkg::t_func                      i_func,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    input  logic signed [COORD_BITS-1:0]        i_point_z,
    input  logic                                i_last_point,
    input  logic [gpb_pkg::GRID_W-1:0]          i_query_cell_x,
    input  logic [gpb_pkg::GRID_W-1:0]          i_query_cell_y,
    input  logic [gpb_pkg::SLOT_W-1:0]          i_query_slot,
    // result fields
    output logic [gpb_pkg::GRID_W-1:0]          o_cell_col,
    output logic [gpb_pkg::GRID_W-1:0]          o_cell_row,
    output logic [gpb_pkg::CNT_W-1:0]           o_cell_count,
    output logic [1:0]                          o_status_code,
    output logic signed [COORD_BITS-1:0]        o_out_x,
    output logic signed [COORD_BITS-1:0]        o_out_y,
    output logic signed [COORD_BITS-1:0]        o_out_z,
    output logic                                o_batch_done
);

    localparam int RW          = COORD_BITS + gpb_pkg::GRID_W;
    localparam int STORE_DEPTH = gpb_pkg::NUM_CELLS * gpb_pkg::CELL_CAP;
    localparam int ADDR_W      = gpb_pkg::CELL_W + gpb_pkg::SLOT_W;
    localparam logic [gpb_pkg::GRID_W-1:0] GRID_MAX = gpb_pkg::GRID_W'(gpb_pkg::GRID_SIDE - 1);

    // Configuration registers
    logic signed [COORD_BITS-1:0] r_origin_x;
    logic signed [COORD_BITS-1:0] r_origin_y;
    logic [COORD_BITS-2:0]        r_cell_w;
    logic [COORD_BITS-2:0]        r_cell_h;
    logic signed [COORD_BITS-1:0] r_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_cell_w   <= (COORD_BITS-1)'(320);
            r_cell_h   <= (COORD_BITS-1)'(1600);
            r_invalid  <= COORD_BITS'(160000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gpb_pkg::CFG_ORIGIN_X:    r_origin_x <= i_cfg_data;
                gpb_pkg::CFG_ORIGIN_Y:    r_origin_y <= i_cfg_data;
                gpb_pkg::CFG_CELL_WIDTH:  r_cell_w   <= i_cfg_data[COORD_BITS-2:0];
                gpb_pkg::CFG_CELL_HEIGHT: r_cell_h   <= i_cfg_data[COORD_BITS-2:0];
                gpb_pkg::CFG_INVALID:     r_invalid  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture
    gpb_pkg::t_func               r_func;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic signed [COORD_BITS-1:0] r_pz;
    logic                         r_last;
    logic [gpb_pkg::SLOT_W-1:0]   r_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_pz   <= i_point_z;
            r_last <= i_last_point;
            r_slot <= i_query_slot;
        end
    end

    // Shared restoring divider, one quotient bit per cycle
    logic [COORD_BITS-1:0]         r_rem;
    logic [COORD_BITS-2:0]         r_len;
    logic                          r_neg;
    logic                          r_sat;
    logic                          r_dim;
    logic [gpb_pkg::GRID_W-1:0]    r_q;
    logic [gpb_pkg::STEP_W-1:0]    r_step;

    logic signed [COORD_BITS-1:0]  ld_coord;
    logic signed [COORD_BITS-1:0]  ld_origin;
    logic [COORD_BITS-2:0]         ld_len;
    logic [COORD_BITS-2:0]         ld_len_eff;
    logic [COORD_BITS:0]           ld_diff;
    logic [RW-1:0]                 ld_lim;
    logic [RW-1:0]                 st_trial;
    logic                          st_ge;
    logic [gpb_pkg::GRID_W-1:0]    st_q;
    logic [gpb_pkg::GRID_W-1:0]    st_fin;

    always_comb begin
        ld_coord   = i_cmd.load_y ? r_py : r_px;
        ld_origin  = i_cmd.load_y ? r_origin_y : r_origin_x;
        ld_len     = i_cmd.load_y ? r_cell_h : r_cell_w;
        // a zero length acts as one
        ld_len_eff = (ld_len == '0) ? (COORD_BITS-1)'(1) : ld_len;
        ld_diff    = {ld_coord[COORD_BITS-1], ld_coord} - {ld_origin[COORD_BITS-1], ld_origin};
        ld_lim     = RW'(ld_len_eff) << gpb_pkg::GRID_W;

        st_trial = RW'(r_len) << r_step;
        st_ge    = (RW'(r_rem) >= st_trial);
        st_q     = r_q;
        st_q[r_step] = st_ge;
        // below the grid goes to zero, beyond it to the last cell
        if (r_neg) begin
            st_fin = '0;
        end else if (r_sat || (st_q > GRID_MAX)) begin
            st_fin = GRID_MAX;
        end else begin
            st_fin = st_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x || i_cmd.load_y) begin
            r_rem  <= ld_diff[COORD_BITS-1:0];
            r_len  <= ld_len_eff;
            r_neg  <= ld_diff[COORD_BITS];
            r_sat  <= (RW'(ld_diff[COORD_BITS-1:0]) >= ld_lim);
            r_dim  <= i_cmd.load_y;
            r_q    <= '0;
            r_step <= gpb_pkg::STEP_W'(gpb_pkg::GRID_W - 1);
        end else if (i_cmd.step) begin
            if (st_ge) begin
                r_rem <= r_rem - st_trial[COORD_BITS-1:0];
            end
            r_q    <= st_q;
            r_step <= r_step - 1'b1;
        end
    end

    // Cell counts: memory plus valid bits that a clear wipes at once
    logic [gpb_pkg::CNT_W-1:0]     r_cnt_mem [gpb_pkg::NUM_CELLS];
    logic [gpb_pkg::NUM_CELLS-1:0] r_cnt_vld;
    logic [gpb_pkg::CNT_W-1:0]     r_cnt_q;
    logic                          r_cnt_qv;
    logic [gpb_pkg::CELL_W-1:0]    cell_idx;
    logic [gpb_pkg::CNT_W-1:0]     cnt_now;
    logic                          cnt_full;

    // Result registers
    logic [gpb_pkg::GRID_W-1:0]    r_col;
    logic [gpb_pkg::GRID_W-1:0]    r_row;
    logic [gpb_pkg::CNT_W-1:0]     r_cnt;
    gpb_pkg::t_status              r_stat;
    logic [COORD_BITS-1:0]         r_ox;
    logic [COORD_BITS-1:0]         r_oy;
    logic [COORD_BITS-1:0]         r_oz;
    logic                          r_done;

    assign cell_idx = {r_col, r_row};
    assign cnt_now  = r_cnt_qv ? r_cnt_q : '0;
    assign cnt_full = (cnt_now >= gpb_pkg::CNT_W'(gpb_pkg::CELL_CAP));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= r_cnt_mem[cell_idx];
        end
        if (i_cmd.ins && !cnt_full) begin
            r_cnt_mem[cell_idx] <= cnt_now + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_cnt_qv  <= 1'b0;
        end else begin
            if (i_cmd.cnt_rd) begin
                r_cnt_qv <= r_cnt_vld[cell_idx];
            end
            if (i_cmd.clr_cnt) begin
                r_cnt_vld <= '0;
            end else if (i_cmd.ins && !cnt_full) begin
                r_cnt_vld[cell_idx] <= 1'b1;
            end
        end
    end

    // Point store, one entry per cell slot
    logic [3*COORD_BITS-1:0] r_store [STORE_DEPTH];
    logic [3*COORD_BITS-1:0] r_store_q;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    slot_empty;

    assign wr_addr    = {cell_idx, cnt_now[gpb_pkg::SLOT_W-1:0]};
    assign rd_addr    = {cell_idx, r_slot};
    assign slot_empty = (gpb_pkg::CNT_W'(r_slot) >= cnt_now);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && !cnt_full) begin
            r_store[wr_addr] <= {r_px, r_py, r_pz};
        end
        if (i_cmd.rd_chk) begin
            r_store_q <= r_store[rd_addr];
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_col <= (i_query_cell_x > GRID_MAX) ? GRID_MAX : i_query_cell_x;
            r_row <= (i_query_cell_y > GRID_MAX) ? GRID_MAX : i_query_cell_y;
        end else if (i_cmd.zero || i_cmd.skip) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.step && (r_step == '0)) begin
            if (r_dim) begin
                r_row <= st_fin;
            end else begin
                r_col <= st_fin;
            end
        end

        if (i_cmd.zero || i_cmd.skip) begin
            r_cnt  <= '0;
            r_stat <= i_cmd.skip ? gpb_pkg::ST_SKIP : gpb_pkg::ST_OK;
            r_ox   <= '0;
            r_oy   <= '0;
            r_oz   <= '0;
            r_done <= i_cmd.skip ? r_last : 1'b0;
        end else if (i_cmd.ins) begin
            r_cnt  <= cnt_full ? cnt_now : cnt_now + 1'b1;
            r_stat <= cnt_full ? gpb_pkg::ST_FULL : gpb_pkg::ST_OK;
            r_ox   <= '0;
            r_oy   <= '0;
            r_oz   <= '0;
            r_done <= r_last;
        end else if (i_cmd.rd_chk) begin
            r_cnt  <= cnt_now;
            r_stat <= slot_empty ? gpb_pkg::ST_EMPTY : gpb_pkg::ST_OK;
            r_done <= 1'b0;
        end else if (i_cmd.rd_cap) begin
            // an empty slot reads back as zero
            if (r_stat == gpb_pkg::ST_OK) begin
                r_ox <= r_store_q[3*COORD_BITS-1:2*COORD_BITS];
                r_oy <= r_store_q[2*COORD_BITS-1:COORD_BITS];
                r_oz <= r_store_q[COORD_BITS-1:0];
            end else begin
                r_ox <= '0;
                r_oy <= '0;
                r_oz <= '0;
            end
        end
    end

    assign o_status.invalid   = (r_px == r_invalid);
    assign o_status.div_last  = (r_step == '0);
    assign o_status.is_insert = (r_func == gpb_pkg::FUNC_INSERT) || (r_func == gpb_pkg::FUNC_NONE);

    assign o_cell_col    = r_col;
    assign o_cell_row    = r_row;
    assign o_cell_count  = r_cnt;
    assign o_status_code = r_stat;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_out_z       = r_oz;
    assign o_batch_done  = r_done;

endmodule

@@ design/grid_point_binning_unit.sv @@
// Grid point binning unit: sorts points into a square grid of cells.
// Request: pulse start with the fields while busy is low; the request is
// taken at that edge. func selects clear counts, insert point or read point.
// Configuration: i_cfg_we writes register i_cfg_idx (origin x, origin y,
// cell width, cell height, invalid marker) with i_cfg_data; the user must
// write only while idle, as the block itself does not enforce it.
// Result: one per request, shown for exactly one cycle with o_valid high;
// the receiver cannot hold it off. busy stays high until that cycle ends.
// Steps from the accepting edge to the result:
//   clear / unused func: clear; insert, skipped point: marker check
//   insert: marker check, x division, y load, y division, count read,
//     point write; the shared divider resolves one index bit per cycle
//   read: count memory read, then point store read
// Next request may start the cycle after the result; one request at a time.
// Reset clears the controller and all cell counts at once (count valid
// bits), loads the configuration defaults; the point store is not cleared.
module grid_point_binning_unit #(
    parameter int COORD_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_func,
    input  logic signed [COORD_BITS-1:0]       i_point_x,
    input  logic signed [COORD_BITS-1:0]       i_point_y,
    input  logic signed [COORD_BITS-1:0]       i_point_z,
    input  logic                               i_last_point,
    input  logic [gpb_pkg::GRID_W-1:0]         i_query_cell_x,
    input  logic [gpb_pkg::GRID_W-1:0]         i_query_cell_y,
    input  logic [gpb_pkg::SLOT_W-1:0]         i_query_slot,
    input  logic                               i_cfg_we,
    input  logic [gpb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [COORD_BITS-1:0]              i_cfg_data,
    output logic                               o_valid,
    output logic [gpb_pkg::GRID_W-1:0]         o_cell_col,
    output logic [gpb_pkg::GRID_W-1:0]         o_cell_row,
    output logic [gpb_pkg::CNT_W-1:0]          o_cell_count,
    output logic [1:0]                         o_status,
    output logic signed [COORD_BITS-1:0]       o_out_x,
    output logic signed [COORD_BITS-1:0]       o_out_y,
    output logic signed [COORD_BITS-1:0]       o_out_z,
    output logic                               o_batch_done
);

`include "grid_point_binning_unit_defines.svh"

    gpb_pkg::t_dp_cmd    cmd;
    gpb_pkg::t_dp_status dp_status;
    gpb_pkg::t_func      func;

    assign func = gpb_pkg::t_func'(i_func);

    gpb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (func),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    gpb_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (dp_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_func         (func),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_last_point   (i_last_point),
        .i_query_cell_x (i_query_cell_x),
        .i_query_cell_y (i_query_cell_y),
        .i_query_slot   (i_query_slot),
        .o_cell_col     (o_cell_col),
        .o_cell_row     (o_cell_row),
        .o_cell_count   (o_cell_count),
        .o_status_code  (o_status),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_batch_done   (o_batch_done)
    );

    // A taken request keeps the block busy
    `GPB_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // Each result lasts one cycle and the block is idle after it
    `GPB_ASSERT_NEXT(a_valid_once, o_valid, !o_valid && !busy)
    // A result only appears while a request is in flight
    `GPB_ASSERT_NOW(a_valid_busy, o_valid, busy)
    // The count written back never exceeds the cell capacity
    `GPB_ASSERT_NOW(a_cnt_cap, o_valid, o_cell_count <= gpb_pkg::CNT_W'(gpb_pkg::CELL_CAP))

endmodule
